/* sv/lfsm_pkg.sv */
// Package for the line filter substring match unit.
// Holds sizes, character codes, register indexes, item types and the
// emitter state type. No dependencies.
package lfsm_pkg;

	localparam int LINE_BYTES  = 64;
	localparam int PATTERN_MAX = 8;

	localparam int BYTE_W     = 8;
	localparam int LINENUM_W  = 16;
	localparam int PLEN_W     = 4;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int PAT_W      = BYTE_W * PATTERN_MAX;

	// Line length counts up to LINE_BYTES itself; addresses only reach LINE_BYTES-1.
	localparam int LEN_W  = $clog2(LINE_BYTES + 1);
	localparam int ADDR_W = $clog2(LINE_BYTES);
	localparam int FILL_W = $clog2(PATTERN_MAX + 1);
	localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_stream;
	} text_item_t;

	typedef struct packed {
		logic [LINENUM_W-1:0] line_number;
		logic [BYTE_W-1:0]    line_byte;
		logic                 last_byte;
		logic                 truncated;
	} match_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SEND
	} emit_state_t;

endpackage

/* sv/lfsm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the line store.
module lfsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/lfsm_cell.sv */
// One cell of the recent-byte window: holds one byte, hands it to the next
// cell on each shift and compares its incoming byte with its pattern byte.
// Depends on lfsm_pkg.
module lfsm_cell
	import lfsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic              clear,
	input  logic [BYTE_W-1:0] din,
	input  logic [BYTE_W-1:0] want,
	input  logic              active,
	output logic [BYTE_W-1:0] dout,
	output logic              hit
);

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= din;
		end
	end

	// The compare looks at the byte this cell takes on the current shift.
	assign hit  = !active || (din == want);
	assign dout = byte_q;

endmodule

/* sv/line_filter_substring_match_unit.sv */
// Line filter substring match unit: top level with window cells and line store.
// After a matched line closes, the emitter reads the line store, then sends.
// Throughput: one text item per cycle; while a matched line is sent the input
// is stalled and each result takes one line store read plus one send.
// Reset (arst_n low) clears control state, sets pattern length 1, line number 1;
// the line store is not cleared and is only read below the written length.
module line_filter_substring_match_unit
	import lfsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  text_item_t            byte_item,
	output logic                  match_valid,
	input  logic                  match_stall,
	output match_item_t           match_item
);

	logic [PAT_W-1:0]     pattern_q;
	logic [PLEN_W-1:0]    plen_q;
	logic [LEN_W-1:0]     len_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 match_q;
	logic                 ovf_q;
	logic [LINENUM_W-1:0] line_cnt_q;

	emit_state_t          state_q, state_d;
	logic [ADDR_W-1:0]    ptr_q;
	logic [ADDR_W-1:0]    last_q;
	logic [LINENUM_W-1:0] num_q;
	logic                 trunc_q;

	logic              accept, is_delim, take, close, start_emit;
	logic              ram_we, ram_re, out_accept, send_last;
	logic [LEN_W-1:0]  len_d;
	logic              ovf_d, match_d, hit_all;
	logic [FILL_W-1:0] fill_d, act_n;
	logic [BYTE_W-1:0] rd_byte;

	logic [BYTE_W-1:0] pat_byte  [PATTERN_MAX];
	logic [BYTE_W-1:0] cell_out  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] cell_hit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= PLEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_BYTES:  pattern_q <= cfg_data[PAT_W-1:0];
				CFG_PATTERN_LENGTH: plen_q    <= cfg_data[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Pattern length clamped to 1..PATTERN_MAX.
	always_comb begin
		if (plen_q == '0) begin
			act_n = FILL_W'(1);
		end else if (FILL_W'(plen_q) > FILL_W'(PATTERN_MAX)) begin
			act_n = FILL_W'(PATTERN_MAX);
		end else begin
			act_n = FILL_W'(plen_q);
		end
	end

	assign accept   = byte_valid && !byte_stall;
	assign is_delim = (byte_item.data_byte == CHAR_LF) || (byte_item.data_byte == CHAR_CR);
	assign take     = accept && !is_delim;
	assign close    = accept && (is_delim || byte_item.end_of_stream);

	// Window cells: cell 0 takes the newest byte, each cell feeds the next one.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [FILL_W-1:0] idx;
		logic [BYTE_W-1:0] cin;

		assign pat_byte[k] = pattern_q[k*BYTE_W +: BYTE_W];
		// Cell k lines up with pattern character act_n-1-k.
		assign idx = act_n - FILL_W'(1) - FILL_W'(k);
		if (k == 0) begin : g_head
			assign cin = byte_item.data_byte;
		end else begin : g_link
			assign cin = cell_out[k-1];
		end

		lfsm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (take),
			.clear  (close),
			.din    (cin),
			.want   (pat_byte[idx[PIDX_W-1:0]]),
			.active (FILL_W'(k) < act_n),
			.dout   (cell_out[k]),
			.hit    (cell_hit[k])
		);
	end

	assign hit_all = &cell_hit;

	always_comb begin
		fill_d  = fill_q;
		len_d   = len_q;
		ovf_d   = ovf_q;
		ram_we  = 1'b0;
		if (take) begin
			if (fill_q < FILL_W'(PATTERN_MAX)) begin
				fill_d = fill_q + FILL_W'(1);
			end
			if (len_q < LEN_W'(LINE_BYTES)) begin
				ram_we = 1'b1;
				len_d  = len_q + LEN_W'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end
		match_d = match_q || (take && (fill_d >= act_n) && hit_all);
	end

	assign start_emit = close && match_d && (len_d != '0);

	// Line state of the open line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			fill_q     <= '0;
			match_q    <= 1'b0;
			ovf_q      <= 1'b0;
			line_cnt_q <= LINENUM_W'(1);
		end else if (close) begin
			len_q   <= '0;
			fill_q  <= '0;
			match_q <= 1'b0;
			ovf_q   <= 1'b0;
			// After the end of the stream numbering restarts.
			line_cnt_q <= byte_item.end_of_stream ? LINENUM_W'(1)
				: line_cnt_q + LINENUM_W'(1);
		end else if (take) begin
			len_q   <= len_d;
			fill_q  <= fill_d;
			match_q <= match_d;
			ovf_q   <= ovf_d;
		end
	end

	lfsm_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LINE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q[ADDR_W-1:0]),
		.wdata (byte_item.data_byte),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (rd_byte)
	);

	assign out_accept = match_valid && !match_stall;
	assign send_last  = (ptr_q == last_q);

	// Emitter next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_emit) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_SEND;
			ST_SEND: begin
				if (out_accept) begin
					state_d = send_last ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Emitter outputs.
	always_comb begin
		byte_stall  = 1'b1;
		ram_re      = 1'b0;
		match_valid = 1'b0;
		case (state_q)
			ST_IDLE: byte_stall  = 1'b0;
			ST_READ: ram_re      = 1'b1;
			ST_SEND: match_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start_emit) begin
				ptr_q <= '0;
			end else if (out_accept && !send_last) begin
				ptr_q <= ptr_q + ADDR_W'(1);
			end
		end
	end

	// Line details captured when a matched line closes.
	always_ff @(posedge clk) begin
		if (start_emit) begin
			last_q  <= ADDR_W'(len_d - LEN_W'(1));
			num_q   <= line_cnt_q;
			trunc_q <= ovf_d;
		end
	end

	assign match_item.line_number = num_q;
	assign match_item.line_byte   = rd_byte;
	assign match_item.last_byte   = send_last;
	assign match_item.truncated   = trunc_q;

	a_no_write_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !ram_we)
		else $error("line store written while a line is being sent");

	a_read_then_send: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_SEND))
		else $error("line store read not followed by a send");

	a_ptr_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (ptr_q <= last_q))
		else $error("read pointer beyond the end of the line");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && match_item.last_byte) |=> (state_q == ST_IDLE))
		else $error("emitter busy after the last byte of a line");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_BYTES))
		else $error("line length beyond the line store");

endmodule
